// ----- rtl/eabv_pkg.sv -----
// Package for the Euler angles to basis vectors unit.
// Holds the angle constants and the shared fixed-point helper function.
// No dependencies.
package eabv_pkg;

  localparam int unsigned AngW = 17;
  localparam int unsigned OutW = 16;
  localparam logic signed [18:0] HalfTurn = 19'sd23040;
  localparam logic signed [18:0] FullTurn = 19'sd46080;
  localparam logic signed [18:0] QuarterTurn = 19'sd11520;

  // Reciprocals for exact floor division by constants. Each one is rounded
  // up, and the error stays small enough for the operand range it serves.
  localparam int unsigned Y0Div = 2025;
  localparam logic [27:0] RecipY0Hi = 28'd135742177;  // ceil(2^38 / 2025)
  localparam logic [25:0] RecipY0Lo = 26'd33935545;   // ceil(2^36 / 2025)
  localparam logic [30:0] RecipFive = 31'd1717986919; // ceil(2^33 / 5)

  // Round a signed 64-bit value to nearest by 2^30, halves away from zero.
  function automatic logic signed [33:0] rnd30(input logic signed [63:0] v);
    logic [63:0] m;
    logic [63:0] r;
    begin
      m = v[63] ? (64'd0 - v) : v;
      r = (m + (64'd1 << 29)) >> 30;
      rnd30 = v[63] ? -$signed(r[33:0]) : $signed(r[33:0]);
    end
  endfunction

endpackage

// ----- rtl/eabv_sine.sv -----
// Pipelined parabolic sine in Q2.30, five register stages.
// Depends on eabv_pkg for the angle constants and rounding helper.
module eabv_sine (
  input  logic                      clk,
  input  logic                      en,
  input  logic signed [18:0]        ang,
  output logic signed [33:0]        sin_q30
);

  // Stage 1: wrap and clamp, then form a*(H-|a|).
  logic signed [18:0] a_w;
  logic signed [18:0] a_abs;
  logic signed [36:0] prod_nxt;
  logic signed [36:0] prod_r;
  always_comb begin
    a_w = ang;
    if (a_w >= eabv_pkg::HalfTurn) a_w = a_w - eabv_pkg::FullTurn;
    if (a_w <= -eabv_pkg::HalfTurn) a_w = a_w + eabv_pkg::FullTurn;
    if (a_w > eabv_pkg::HalfTurn) a_w = eabv_pkg::HalfTurn;
    if (a_w < -eabv_pkg::HalfTurn) a_w = -eabv_pkg::HalfTurn;
    a_abs = a_w[18] ? -a_w : a_w;
    prod_nxt = 37'(a_w * (eabv_pkg::HalfTurn - a_abs));
  end

  // Stage 2: y0 = round(p*2^32/H^2) = floor((|p|*2^14 + 1012) / 2025).
  // Split |p| = q1*2025 + r1 first, with a reciprocal multiply.
  logic [26:0] pm;
  logic [54:0] qa_full;
  logic [16:0] q1_nxt;
  logic [10:0] r1_nxt;
  logic [16:0] q1_r;
  logic [10:0] r1_r;
  logic neg1_r;
  always_comb begin
    pm = prod_r[36] ? 27'(-prod_r) : 27'(prod_r);
    qa_full = 55'(pm) * 55'(eabv_pkg::RecipY0Hi);
    q1_nxt = qa_full[54:38];
    r1_nxt = 11'(pm - 27'(q1_nxt) * 27'(eabv_pkg::Y0Div));
  end

  // Stage 3: y0 = q1*2^14 + floor((r1*2^14 + 1012) / 2025), then the sign.
  logic [24:0] n2;
  logic [50:0] qb_full;
  logic [14:0] q2;
  logic [30:0] y0m;
  logic signed [33:0] y0_nxt;
  logic signed [33:0] y0_r;
  always_comb begin
    n2 = {r1_r, 14'd0} + 25'd1012;
    qb_full = 51'(n2) * 51'(eabv_pkg::RecipY0Lo);
    q2 = qb_full[50:36];
    y0m = {q1_r, 14'd0} + 31'(q2);
    y0_nxt = neg1_r ? -$signed({3'b0, y0m}) : $signed({3'b0, y0m});
  end

  // Stage 4: q = round(y0*|y0| / 2^30).
  logic signed [33:0] q_nxt;
  logic signed [33:0] q_r;
  logic signed [33:0] y0b_r;
  always_comb begin
    q_nxt = eabv_pkg::rnd30(64'(y0_r * (y0_r[33] ? -y0_r : y0_r)));
  end

  // Stage 5: s = y0 + round((q-y0)*9/40), dividing by 8 and then by 5.
  logic signed [39:0] d9;
  logic [39:0] dm;
  logic [29:0] d8;
  logic [60:0] dq_full;
  logic [27:0] dq;
  logic signed [33:0] s_nxt;
  always_comb begin
    d9 = 40'(q_r - y0b_r) * 40'sd9;
    dm = d9[39] ? 40'(-d9) : 40'(d9);
    d8 = 30'((dm + 40'd20) >> 3);
    dq_full = 61'(d8) * 61'(eabv_pkg::RecipFive);
    dq = dq_full[60:33];
    s_nxt = y0b_r + (d9[39] ? -$signed({6'b0, dq}) : $signed({6'b0, dq}));
  end

  always_ff @(posedge clk) begin
    if (en) begin
      prod_r <= prod_nxt;
      q1_r <= q1_nxt;
      r1_r <= r1_nxt;
      neg1_r <= prod_r[36];
      y0_r <= y0_nxt;
      q_r <= q_nxt;
      y0b_r <= y0_r;
      sin_q30 <= s_nxt;
    end
  end

endmodule

// ----- rtl/euler_angles_to_basis_vectors_unit.sv -----
// Top level of the Euler angles to basis vectors unit.
// Depends on eabv_pkg and eabv_sine.
//
// Usage: one item carries yaw, pitch and roll in degrees times 128. Each
// result item holds the forward, right and up vectors in signed fixed
// point with OUT_FRAC_BITS fractional bits, saturated to 16 bits.
// Channels use valid and stall; an item moves when valid is high and stall
// is low. The pipeline is eight register stages deep: five for the sine
// units, one for the Q30 cross products, one for the Q60 sums and one for
// rounding and saturation into the output register.
// Throughput is one item every cycle while the receiver does not stall.
// When the receiver stalls with a result waiting, the whole pipeline
// holds and in_stall rises, so nothing is lost or repeated.
// Reset clears the valid bits only; payload registers are not reset.
// While reset is held, in_stall is high and no item is taken.
module euler_angles_to_basis_vectors_unit #(
  parameter int OUT_FRAC_BITS = 14
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [16:0] in_yaw_deg,
  input  logic signed [16:0] in_pitch_deg,
  input  logic signed [16:0] in_roll_deg,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [15:0] out_forward_x,
  output logic signed [15:0] out_forward_y,
  output logic signed [15:0] out_forward_z,
  output logic signed [15:0] out_right_x,
  output logic signed [15:0] out_right_y,
  output logic signed [15:0] out_right_z,
  output logic signed [15:0] out_up_x,
  output logic signed [15:0] out_up_y,
  output logic signed [15:0] out_up_z
);

  localparam int Depth = 8;
  localparam int Sh = 60 - OUT_FRAC_BITS;

  // Pipeline advances unless a finished result is held.
  logic en;
  logic [Depth-1:0] vld_r;
  assign en = !(vld_r[Depth-1] && out_stall);
  assign in_stall = !en || !rst_n;
  assign out_valid = vld_r[Depth-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[Depth-2:0], in_valid};
    end
  end

  // Six sine units; cosine is sine of angle plus 90 degrees.
  logic signed [18:0] ang [6];
  logic signed [33:0] sv [6];
  assign ang[0] = 19'(in_yaw_deg);
  assign ang[1] = 19'(in_yaw_deg) + eabv_pkg::QuarterTurn;
  assign ang[2] = 19'(in_pitch_deg);
  assign ang[3] = 19'(in_pitch_deg) + eabv_pkg::QuarterTurn;
  assign ang[4] = 19'(in_roll_deg);
  assign ang[5] = 19'(in_roll_deg) + eabv_pkg::QuarterTurn;

  for (genvar g = 0; g < 6; g++) begin : g_sin
    eabv_sine u_sin (.clk(clk), .en(en), .ang(ang[g]), .sin_q30(sv[g]));
  end

  // Stage 6: two-factor partial products rounded to Q30.
  logic signed [33:0] sy_r, cy_r, sp_r, cp_r, sr_r, cr_r, srsp_r, crsp_r;
  always_ff @(posedge clk) begin
    if (en) begin
      sy_r <= sv[0];
      cy_r <= sv[1];
      sp_r <= sv[2];
      cp_r <= sv[3];
      sr_r <= sv[4];
      cr_r <= sv[5];
      srsp_r <= eabv_pkg::rnd30(64'(sv[4] * sv[2]));
      crsp_r <= eabv_pkg::rnd30(64'(sv[5] * sv[2]));
    end
  end

  // Stage 7: Q60 component sums.
  logic signed [69:0] c_r [9];
  always_ff @(posedge clk) begin
    if (en) begin
      c_r[0] <= 70'(cp_r * cy_r);
      c_r[1] <= 70'(cp_r * sy_r);
      c_r[2] <= -(70'(sp_r) <<< 30);
      c_r[3] <= -70'(srsp_r * cy_r) + 70'(cr_r * sy_r);
      c_r[4] <= -70'(srsp_r * sy_r) - 70'(cr_r * cy_r);
      c_r[5] <= -70'(sr_r * cp_r);
      c_r[6] <= 70'(crsp_r * cy_r) + 70'(sr_r * sy_r);
      c_r[7] <= 70'(crsp_r * sy_r) - 70'(sr_r * cy_r);
      c_r[8] <= 70'(cr_r * cp_r);
    end
  end

  // Stage 8: round to output format and saturate.
  logic signed [15:0] o_r [9];
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 9; i++) begin
        logic [69:0] m;
        logic [69:0] rr;
        logic signed [70:0] v;
        m = c_r[i][69] ? 70'(-c_r[i]) : 70'(c_r[i]);
        rr = (m + (70'd1 << (Sh - 1))) >> Sh;
        v = c_r[i][69] ? -$signed({1'b0, rr}) : $signed({1'b0, rr});
        if (v > 71'sd32767) o_r[i] <= 16'sh7fff;
        else if (v < -71'sd32768) o_r[i] <= -16'sh8000;
        else o_r[i] <= v[15:0];
      end
    end
  end

  assign out_forward_x = o_r[0];
  assign out_forward_y = o_r[1];
  assign out_forward_z = o_r[2];
  assign out_right_x = o_r[3];
  assign out_right_y = o_r[4];
  assign out_right_z = o_r[5];
  assign out_up_x = o_r[6];
  assign out_up_y = o_r[7];
  assign out_up_z = o_r[8];

  // A held result stays valid and keeps out_up_z stable while stalled.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_up_z))
    else $error("held result changed");
  // Input is stalled exactly when the output holds.
  assert property (@(posedge clk) disable iff (!rst_n)
    in_stall == (out_valid && out_stall))
    else $error("stall mismatch");

endmodule
